/* hdl/frg_pkg.sv */
// Shared constants and types of the fragment reassembler.
`default_nettype none
package frg_pkg;

  localparam int CHANNELS     = 8;
  localparam int BUFFER_BYTES = 256;
  localparam int CHAN_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OFF_W        = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int STORE_DEPTH  = CHANNELS << OFF_W;
  localparam int STORE_AW     = CHAN_W + OFF_W;
  localparam int TIME_W       = 48;
  localparam int LEN_W        = 9;
  localparam int FC_W         = 10;

  // Command codes.
  localparam logic [2:0] CMD_FRAG  = 3'd0;
  localparam logic [2:0] CMD_TICK  = 3'd1;
  localparam logic [2:0] CMD_RST   = 3'd2;
  localparam logic [2:0] CMD_RSTA  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_DELIV  = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;
  localparam logic [1:0] ST_RDATA  = 2'd3;

  // Operands of the shared add / subtract unit.
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

endpackage
`default_nettype wire

/* hdl/frg_if.sv */
// Handshake channels of the fragment reassembler.
`default_nettype none
interface frg_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  chan;
  logic [7:0]  msg_type;
  logic        first_frag;
  logic        more_frags;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        frag_end;
  logic [47:0] now;
  logic [7:0]  read_index;
  modport source (output valid, cmd, chan, msg_type, first_frag, more_frags, data_byte,
                  has_byte, frag_end, now, read_index, input ready);
  modport sink (input valid, cmd, chan, msg_type, first_frag, more_frags, data_byte,
                has_byte, frag_end, now, read_index, output ready);
endinterface

interface frg_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_chan;
  logic [7:0] out_type;
  logic [8:0] msg_length;
  logic [7:0] read_data;
  modport source (output valid, status, out_chan, out_type, msg_length, read_data,
                  input ready);
  modport sink (input valid, status, out_chan, out_type, msg_length, read_data,
                output ready);
endinterface

interface frg_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* hdl/fragment_reassembler.sv */
// Per-channel fragment reassembler: sequencer around one shared adder.
// Fragment bytes pass S_POS, fragment ends S_POS and S_END, reads S_RDA and S_RDD (S_RDA
// alone if out of range), ticks S_TICK over all channels, resets in S_IDLE; one at a time.
// A result waits in an output register; the next item is taken once it is free or taken.
// Reset (rst, synchronous) closes all channels, clears lengths and sets timeout to 1000.
// The message store is not cleared; only written bytes are ever read back.
`default_nettype none
module fragment_reassembler import frg_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  frg_req_if.sink   req,
  frg_rsp_if.source rsp,
  frg_cfg_if.sink   cfg
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POS  = 3'd1;
  localparam logic [2:0] S_END  = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;
  localparam logic [2:0] S_RDA  = 3'd4;
  localparam logic [2:0] S_RDD  = 3'd5;

  localparam logic [7:0]      CHAN_LIMIT = 8'(CHANNELS);
  localparam logic [CHAN_W-1:0] LAST_CH  = CHAN_W'(CHANNELS - 1);
  localparam logic [FC_W-1:0] BUF_LIM    = FC_W'(BUFFER_BYTES);
  localparam logic [TIME_W:0] BUF_LIM_W  = (TIME_W+1)'(BUFFER_BYTES);

  logic [2:0] state;
  logic [31:0] timeout;

  // Latched item.
  logic [7:0]  l_chan;
  logic [7:0]  l_type;
  logic        l_ff, l_mf, l_hb, l_fe;
  logic [7:0]  l_byte;
  logic [47:0] l_now;
  logic [7:0]  l_idx;

  // Per-channel state.
  logic              chan_open     [CHANNELS];
  logic [7:0]        chan_type     [CHANNELS];
  logic [LEN_W-1:0]  chan_fill     [CHANNELS];
  logic [TIME_W-1:0] chan_deadline [CHANNELS];
  logic [LEN_W-1:0]  delivered_len [CHANNELS];
  logic [FC_W-1:0]   frag_count;
  logic [CHAN_W-1:0] tick_i;

  // Output register.
  logic       ovalid;
  logic [1:0] o_status;
  logic [7:0] o_chan, o_type, o_data;
  logic [8:0] o_len;

  logic              chan_ok;
  logic [CHAN_W-1:0] chi;
  alu_req_t          alu_req;
  logic [TIME_W:0]   alu_sum;
  logic              ram_we;
  logic [STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;
  logic              acc;

  assign chan_ok = l_chan < CHAN_LIMIT;
  assign chi     = l_chan[CHAN_W-1:0];
  assign acc     = req.valid && req.ready;

  assign req.ready = (state == S_IDLE) && (!ovalid || rsp.ready);
  assign cfg.ready = 1'b1;

  assign rsp.valid      = ovalid;
  assign rsp.status     = o_status;
  assign rsp.out_chan   = o_chan;
  assign rsp.out_type   = o_type;
  assign rsp.msg_length = o_len;
  assign rsp.read_data  = o_data;

  // Operand selection for the shared adder.
  always_comb begin
    alu_req = '0;
    unique case (state)
      S_POS: begin
        alu_req.a = l_ff ? '0 : TIME_W'(chan_fill[chi]);
        alu_req.b = TIME_W'(frag_count);
      end
      S_END: begin
        if (l_ff) begin
          alu_req.a = l_now;
          alu_req.b = TIME_W'(timeout);
        end else begin
          alu_req.a = TIME_W'(chan_fill[chi]);
          alu_req.b = TIME_W'(frag_count);
        end
      end
      S_TICK: begin
        alu_req.a   = l_now;
        alu_req.b   = chan_deadline[tick_i];
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  frg_alu u_alu (.req(alu_req), .sum(alu_sum));

  // Store write on an in-range fragment byte.
  assign ram_we = (state == S_POS) && chan_ok && l_hb && (l_ff || chan_open[chi])
                  && (alu_sum < BUF_LIM_W);
  assign ram_waddr = {chi, alu_sum[OFF_W-1:0]};
  assign ram_raddr = {chi, l_idx[OFF_W-1:0]};

  frg_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(l_byte),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= 32'd1000;
    end else if (cfg.valid && cfg.ready) begin
      timeout <= cfg.data;
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (acc) begin
      l_chan <= req.chan;
      l_type <= req.msg_type;
      l_ff   <= req.first_frag;
      l_mf   <= req.more_frags;
      l_hb   <= req.has_byte;
      l_fe   <= req.frag_end;
      l_byte <= req.data_byte;
      l_now  <= req.now;
      l_idx  <= req.read_index;
    end
  end

  // Sequencer, channel state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      frag_count <= '0;
      tick_i     <= '0;
      ovalid     <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_open[i]     <= 1'b0;
        chan_type[i]     <= '0;
        chan_fill[i]     <= '0;
        chan_deadline[i] <= '0;
        delivered_len[i] <= '0;
      end
    end else begin
      if (ovalid && rsp.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (req.cmd)
              CMD_FRAG: state <= S_POS;
              CMD_TICK: begin
                tick_i <= '0;
                state  <= S_TICK;
              end
              CMD_RST: begin
                if (req.chan < CHAN_LIMIT) begin
                  chan_open[req.chan[CHAN_W-1:0]]     <= 1'b0;
                  chan_fill[req.chan[CHAN_W-1:0]]     <= '0;
                  chan_deadline[req.chan[CHAN_W-1:0]] <= '0;
                  delivered_len[req.chan[CHAN_W-1:0]] <= '0;
                end
              end
              CMD_RSTA: begin
                frag_count <= '0;
                for (int i = 0; i < CHANNELS; i++) begin
                  chan_open[i]     <= 1'b0;
                  chan_type[i]     <= '0;
                  chan_fill[i]     <= '0;
                  chan_deadline[i] <= '0;
                  delivered_len[i] <= '0;
                end
              end
              CMD_READ: state <= S_RDA;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_POS: begin
          if (ram_we) begin
            delivered_len[chi] <= '0;
          end
          if (chan_ok && l_hb && frag_count <= BUF_LIM) begin
            frag_count <= frag_count + 1'b1;
          end
          state <= l_fe ? S_END : S_IDLE;
        end
        S_END: begin
          frag_count <= '0;
          state      <= S_IDLE;
          ovalid     <= 1'b1;
          o_chan     <= l_chan;
          o_data     <= '0;
          if (!chan_ok) begin
            o_status <= ST_ERROR;
            o_type   <= '0;
            o_len    <= '0;
          end else if (frag_count > BUF_LIM) begin
            chan_open[chi] <= 1'b0;
            chan_fill[chi] <= '0;
            o_status       <= ST_ERROR;
            o_type         <= '0;
            o_len          <= '0;
          end else if (l_ff && !l_mf) begin
            chan_open[chi]     <= 1'b0;
            chan_fill[chi]     <= '0;
            chan_deadline[chi] <= '0;
            chan_type[chi]     <= l_type;
            delivered_len[chi] <= frag_count[LEN_W-1:0];
            o_status           <= ST_DELIV;
            o_type             <= l_type;
            o_len              <= frag_count[LEN_W-1:0];
          end else if (l_ff) begin
            chan_open[chi]     <= 1'b1;
            chan_type[chi]     <= l_type;
            chan_fill[chi]     <= frag_count[LEN_W-1:0];
            chan_deadline[chi] <= alu_sum[TIME_W] ? '1 : alu_sum[TIME_W-1:0];
            o_status           <= ST_NONE;
            o_type             <= '0;
            o_len              <= '0;
          end else if (!chan_open[chi]) begin
            o_status <= ST_NONE;
            o_type   <= '0;
            o_len    <= '0;
          end else if (l_type != chan_type[chi] || alu_sum > BUF_LIM_W) begin
            chan_open[chi] <= 1'b0;
            chan_fill[chi] <= '0;
            o_status       <= ST_ERROR;
            o_type         <= '0;
            o_len          <= '0;
          end else if (l_mf) begin
            chan_fill[chi] <= alu_sum[LEN_W-1:0];
            o_status       <= ST_NONE;
            o_type         <= '0;
            o_len          <= '0;
          end else begin
            chan_open[chi]     <= 1'b0;
            chan_fill[chi]     <= '0;
            chan_deadline[chi] <= '0;
            delivered_len[chi] <= alu_sum[LEN_W-1:0];
            o_status           <= ST_DELIV;
            o_type             <= chan_type[chi];
            o_len              <= alu_sum[LEN_W-1:0];
          end
        end
        S_TICK: begin
          // The subtract does not borrow when now has reached the deadline.
          if (chan_open[tick_i] && !alu_sum[TIME_W]) begin
            chan_open[tick_i]     <= 1'b0;
            chan_fill[tick_i]     <= '0;
            chan_deadline[tick_i] <= '0;
          end
          tick_i <= tick_i + 1'b1;
          if (tick_i == LAST_CH) begin
            state <= S_IDLE;
          end
        end
        S_RDA: begin
          if (chan_ok && {1'b0, l_idx} < delivered_len[chi]) begin
            state <= S_RDD;
          end else begin
            state    <= S_IDLE;
            ovalid   <= 1'b1;
            o_status <= ST_ERROR;
            o_chan   <= l_chan;
            o_type   <= '0;
            o_len    <= '0;
            o_data   <= '0;
          end
        end
        S_RDD: begin
          state    <= S_IDLE;
          ovalid   <= 1'b1;
          o_status <= ST_RDATA;
          o_chan   <= l_chan;
          o_type   <= chan_type[chi];
          o_len    <= delivered_len[chi];
          o_data   <= ram_rdata;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The input side is closed while the sequencer is busy.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("ready while busy");

  // The fragment byte count never passes its saturation value.
  a_fc_sat: assert property (@(posedge clk) disable iff (rst)
    frag_count <= BUF_LIM + 1'b1) else $error("fragment count overrun");

  // A tick sweep ends after the last channel.
  a_tick_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK && tick_i == LAST_CH) |=> (state == S_IDLE))
    else $error("tick sweep did not end");

  // A new result is only formed while the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_END) |-> (!ovalid)) else $error("result overwritten");

endmodule
`default_nettype wire

/* hdl/frg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module frg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/frg_alu.sv */
// Shared 48-bit adder / subtractor for the byte position, length, deadline and tick steps.
`default_nettype none
module frg_alu import frg_pkg::*; (
  input  wire alu_req_t          req,
  output      logic [TIME_W:0]   sum
);

  // Bit TIME_W is the carry of an add or the borrow of a subtract.
  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
  end

endmodule
`default_nettype wire

/* tb/sv/reasm_checker.sv */
// Checker for the fragment reassembler: predicts every result and compares it.
`timescale 1ns / 1ps
module reasm_checker import frg_pkg::*; (
  input  logic clk,
  input  logic rst,
  frg_req_if   req,
  frg_rsp_if   rsp,
  frg_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   delivered_seen,
  output int   rdata_seen,
  output int   error_seen
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] chan;
    logic [7:0] mtype;
    logic [8:0] len;
    logic [7:0] rdata;
  } result_t;

  // Results owed by the block, oldest first.
  result_t expected_results[$];

  // Shadow copy of the channel state.
  logic              chan_is_open[CHANNELS];
  logic [7:0]        chan_msg_type[CHANNELS];
  int unsigned       chan_fill_len[CHANNELS];
  logic [TIME_W-1:0] chan_due[CHANNELS];
  int unsigned       chan_done_len[CHANNELS];
  logic [7:0]        byte_store[CHANNELS*BUFFER_BYTES];
  int unsigned       frag_bytes;
  logic [31:0]       tmo_value;

  task clear_channels();
    for (int i = 0; i < CHANNELS; i++) begin
      chan_is_open[i]  = 1'b0;
      chan_msg_type[i] = '0;
      chan_fill_len[i] = 0;
      chan_due[i]      = '0;
      chan_done_len[i] = 0;
    end
    frag_bytes = 0;
  endtask

  task close_channel(input int unsigned ch);
    chan_is_open[ch]  = 1'b0;
    chan_fill_len[ch] = 0;
  endtask

  // Work out the result of one accepted input beat, if it has one.
  task reassemble_beat();
    int unsigned ch;
    int unsigned pos;
    int unsigned n;
    logic [TIME_W:0] due_sum;
    result_t e;
    bit gives;
    ch      = req.chan;
    e       = '0;
    e.chan  = req.chan;
    gives   = 1'b0;
    case (req.cmd)
      CMD_FRAG: begin
        if (ch < CHANNELS && req.has_byte) begin
          pos = BUFFER_BYTES;
          if (req.first_frag) pos = frag_bytes;
          else if (chan_is_open[ch]) pos = chan_fill_len[ch] + frag_bytes;
          if (pos < BUFFER_BYTES) begin
            byte_store[ch*BUFFER_BYTES + pos] = req.data_byte;
            chan_done_len[ch] = 0;
          end
          if (frag_bytes <= BUFFER_BYTES) frag_bytes++;
        end
        if (req.frag_end) begin
          gives      = 1'b1;
          n          = frag_bytes;
          frag_bytes = 0;
          if (ch >= CHANNELS) begin
            e.status = ST_ERROR;
          end else if (n > BUFFER_BYTES) begin
            close_channel(ch);
            e.status = ST_ERROR;
          end else if (req.first_frag && !req.more_frags) begin
            // A lone fragment is a whole message.
            close_channel(ch);
            chan_due[ch]      = '0;
            chan_msg_type[ch] = req.msg_type;
            chan_done_len[ch] = n;
            e.status = ST_DELIV;
            e.mtype  = req.msg_type;
            e.len    = 9'(n);
          end else if (req.first_frag) begin
            // Opening fragment: the deadline saturates at the top of the time range.
            due_sum           = {1'b0, req.now} + tmo_value;
            chan_is_open[ch]  = 1'b1;
            chan_msg_type[ch] = req.msg_type;
            chan_fill_len[ch] = n;
            chan_due[ch]      = due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];
          end else if (!chan_is_open[ch]) begin
            e.status = ST_NONE;
          end else if (req.msg_type != chan_msg_type[ch] ||
                       chan_fill_len[ch] + n > BUFFER_BYTES) begin
            close_channel(ch);
            e.status = ST_ERROR;
          end else if (req.more_frags) begin
            chan_fill_len[ch] += n;
          end else begin
            n += chan_fill_len[ch];
            close_channel(ch);
            chan_due[ch]      = '0;
            chan_done_len[ch] = n;
            e.status = ST_DELIV;
            e.mtype  = chan_msg_type[ch];
            e.len    = 9'(n);
          end
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (chan_is_open[i] && req.now >= chan_due[i]) begin
            close_channel(i);
            chan_due[i] = '0;
          end
        end
      end
      CMD_RST: begin
        if (ch < CHANNELS) begin
          close_channel(ch);
          chan_due[ch]      = '0;
          chan_done_len[ch] = 0;
        end
      end
      CMD_RSTA: clear_channels();
      CMD_READ: begin
        gives = 1'b1;
        if (ch < CHANNELS && req.read_index < chan_done_len[ch]) begin
          e.status = ST_RDATA;
          e.mtype  = chan_msg_type[ch];
          e.len    = 9'(chan_done_len[ch]);
          e.rdata  = byte_store[ch*BUFFER_BYTES + req.read_index];
        end else begin
          e.status = ST_ERROR;
        end
      end
      default: ;
    endcase
    if (gives) expected_results.push_back(e);
  endtask

  // Compare one result beat with the oldest expectation.
  task compare_result();
    result_t e;
    if (expected_results.size() == 0) begin
      $error("result beat with nothing expected: status %0d chan %0d",
             rsp.status, rsp.out_chan);
      fail_count++;
    end else begin
      e = expected_results.pop_front();
      if (rsp.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, rsp.status);
        fail_count++;
      end
      if (rsp.out_chan !== e.chan) begin
        $error("out_chan: expected %0d, actual %0d", e.chan, rsp.out_chan);
        fail_count++;
      end
      if (rsp.out_type !== e.mtype) begin
        $error("out_type: expected %0d, actual %0d", e.mtype, rsp.out_type);
        fail_count++;
      end
      if (rsp.msg_length !== e.len) begin
        $error("msg_length: expected %0d, actual %0d", e.len, rsp.msg_length);
        fail_count++;
      end
      if (rsp.read_data !== e.rdata) begin
        $error("read_data: expected %0d, actual %0d", e.rdata, rsp.read_data);
        fail_count++;
      end
      if (e.status == ST_DELIV) delivered_seen++;
      if (e.status == ST_RDATA) rdata_seen++;
      if (e.status == ST_ERROR) error_seen++;
    end
  endtask

  // Results are checked before the same edge's input beat is modeled.
  always @(posedge clk) begin
    if (rst) begin
      clear_channels();
      tmo_value = 32'd1000;
      expected_results.delete();
      fail_count     = 0;
      delivered_seen = 0;
      rdata_seen     = 0;
      error_seen     = 0;
    end else begin
      if (rsp.valid && rsp.ready) compare_result();
      if (cfg.valid && cfg.ready) tmo_value = cfg.data;
      if (req.valid && req.ready) reassemble_beat();
    end
    pending = expected_results.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the fragment reassembler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import frg_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 20;
  localparam int PHASE_BEATS = 100;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  chan;
    logic [7:0]  msg_type;
    logic        first_frag;
    logic        more_frags;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        frag_end;
    logic [47:0] now;
    logic [7:0]  read_index;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  frg_req_if req_ch();
  frg_rsp_if rsp_ch();
  frg_cfg_if cfg_ch();

  int fail_count, pending, delivered_seen, rdata_seen, error_seen;
  int beats_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int idle_cycles = 0;
  logic [47:0] now_ms = '0;

  fragment_reassembler u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  reasm_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .cfg            (cfg_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .delivered_seen (delivered_seen),
    .rdata_seen     (rdata_seen),
    .error_seen     (error_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Watchdog: too long without any beat moving ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic beat_t blank_beat(input logic [2:0] cmd, input logic [7:0] chan);
    beat_t b;
    b.cmd        = cmd;
    b.chan       = chan;
    b.msg_type   = $urandom_range(0, 255);
    b.first_frag = $urandom_range(0, 1);
    b.more_frags = $urandom_range(0, 1);
    b.data_byte  = $urandom_range(0, 255);
    b.has_byte   = $urandom_range(0, 1);
    b.frag_end   = $urandom_range(0, 1);
    b.now        = now_ms;
    b.read_index = $urandom_range(0, 255);
    return b;
  endfunction

  // Offer one beat after a random gap and hold it until it is taken.
  task send_beat(input beat_t b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= b.cmd;
    req_ch.chan       <= b.chan;
    req_ch.msg_type   <= b.msg_type;
    req_ch.first_frag <= b.first_frag;
    req_ch.more_frags <= b.more_frags;
    req_ch.data_byte  <= b.data_byte;
    req_ch.has_byte   <= b.has_byte;
    req_ch.frag_end   <= b.frag_end;
    req_ch.now        <= b.now;
    req_ch.read_index <= b.read_index;
    do @(posedge clk); while (!req_ch.ready);
    beats_sent++;
  endtask

  // Stop sending and wait until every expected result has arrived.
  task drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_timeout(input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // One fragment of len payload beats on one channel; len 0 is an empty fragment.
  task send_fragment(input logic [7:0] chan, input logic [7:0] mtype, input logic first_f,
                     input logic more_f, input int len);
    beat_t b;
    b = blank_beat(CMD_FRAG, chan);
    b.msg_type   = mtype;
    b.first_frag = first_f;
    b.more_frags = more_f;
    if (len == 0) begin
      b.has_byte = 1'b0;
      b.frag_end = 1'b1;
      send_beat(b);
    end else begin
      for (int i = 0; i < len; i++) begin
        // Now and then an empty beat sits inside the fragment.
        if ($urandom_range(0, 15) == 0) begin
          b.has_byte = 1'b0;
          b.frag_end = 1'b0;
          send_beat(b);
        end
        b.has_byte  = 1'b1;
        b.data_byte = $urandom_range(0, 255);
        b.frag_end  = (i == len - 1);
        send_beat(b);
      end
    end
  endtask

  task send_read(input logic [7:0] chan, input logic [7:0] idx);
    beat_t b;
    b = blank_beat(CMD_READ, chan);
    b.read_index = idx;
    send_beat(b);
  endtask

  task send_cmd(input logic [2:0] cmd, input logic [7:0] chan);
    send_beat(blank_beat(cmd, chan));
  endtask

  // A non-fragment command chosen at random.
  task send_side_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) send_cmd(CMD_TICK, $urandom_range(0, 255));
    else if (r < 70) send_read($urandom_range(0, 9), $urandom_range(0, 255));
    else if (r < 85) send_cmd(CMD_RST, $urandom_range(0, 15));
    else if (r < 90) send_cmd(CMD_RSTA, $urandom_range(0, 255));
    else send_cmd($urandom_range(5, 7), $urandom_range(0, 255));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return $urandom_range(250, 260);
    if (r < 10) return 0;
    return $urandom_range(1, 6);
  endfunction

  // A message of one to four fragments, mostly well formed, sometimes followed by reads of it.
  task send_message();
    logic [7:0] chan;
    logic [7:0] mtype;
    logic [7:0] ftype;
    logic first_f, more_f;
    int nfrag;
    if ($urandom_range(0, 19) == 0) chan = $urandom_range(CHANNELS, 255);
    else chan = $urandom_range(0, CHANNELS - 1);
    mtype = $urandom_range(0, 255);
    nfrag = $urandom_range(1, 4);
    now_ms += $urandom_range(0, 400);
    if ($urandom_range(0, 49) == 0) now_ms = 48'({$urandom, $urandom});
    for (int f = 0; f < nfrag; f++) begin
      first_f = (f == 0);
      more_f  = (f < nfrag - 1);
      ftype   = mtype;
      if ($urandom_range(0, 14) == 0) ftype = $urandom_range(0, 255);
      if ($urandom_range(0, 11) == 0) begin
        first_f = $urandom_range(0, 1);
        more_f  = $urandom_range(0, 1);
      end
      send_fragment(chan, ftype, first_f, more_f, pick_len());
      if ($urandom_range(0, 3) == 0) send_side_cmd();
    end
    if ($urandom_range(0, 1) == 0) begin
      for (int i = $urandom_range(1, 3); i > 0; i--) begin
        if ($urandom_range(0, 9) == 0) send_read(chan, $urandom_range(0, 255));
        else send_read(chan, $urandom_range(0, 8));
      end
    end
  endtask

  task run_phase(input int tx_pct, input int rx_pct, input logic [31:0] tmo);
    int start;
    write_timeout(tmo);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    start = beats_sent;
    while (beats_sent - start < PHASE_BEATS) begin
      if ($urandom_range(0, 4) == 0) send_side_cmd();
      else send_message();
    end
    drain();
  endtask

  initial begin
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= CMD_FRAG;
    req_ch.chan       <= '0;
    req_ch.msg_type   <= '0;
    req_ch.first_frag <= 1'b0;
    req_ch.more_frags <= 1'b0;
    req_ch.data_byte  <= '0;
    req_ch.has_byte   <= 1'b0;
    req_ch.frag_end   <= 1'b0;
    req_ch.now        <= '0;
    req_ch.read_index <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset timeout.
    send_fragment(8'd0, 8'hFF, 1'b1, 1'b0, 2);
    send_read(8'd0, 8'd0);
    send_read(8'd0, 8'd1);
    send_read(8'd0, 8'd2);
    send_fragment(8'd7, 8'h00, 1'b1, 1'b0, 0);
    send_fragment(8'd255, 8'h12, 1'b1, 1'b0, 1);
    send_read(8'd8, 8'd0);
    // Orphan continuation on a closed channel.
    send_fragment(8'd3, 8'h33, 1'b0, 1'b0, 1);
    // Type mismatch on an open channel.
    send_fragment(8'd1, 8'h05, 1'b1, 1'b1, 1);
    send_fragment(8'd1, 8'h06, 1'b0, 1'b0, 1);
    // Three-fragment message, then a read of its last byte.
    send_fragment(8'd2, 8'hA5, 1'b1, 1'b1, 1);
    send_fragment(8'd2, 8'hA5, 1'b0, 1'b1, 1);
    send_fragment(8'd2, 8'hA5, 1'b0, 1'b0, 1);
    send_read(8'd2, 8'd2);
    // Deadline saturates at the top of time; a tick there expires it.
    now_ms = '1;
    send_fragment(8'd4, 8'h44, 1'b1, 1'b1, 1);
    send_cmd(CMD_TICK, 8'd0);
    send_fragment(8'd4, 8'h44, 1'b0, 1'b0, 1);
    send_cmd(CMD_RST, 8'd2);
    send_read(8'd2, 8'd0);
    send_cmd(3'd5, 8'd0);
    send_cmd(3'd7, 8'd0);
    send_cmd(CMD_RSTA, 8'd0);
    send_read(8'd0, 8'd0);
    now_ms = '0;
    drain();

    // Random part in idling phases, each with its own timeout.
    run_phase(0, 0, 32'd0);
    run_phase(85, 0, 32'hFFFF_FFFF);
    run_phase(0, 85, 32'd200);
    run_phase(6, 6, $urandom);

    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("Covered %0d input beats over four idling phases and timeouts 0 to max.",
             beats_sent);
    $display("Checked %0d deliveries, %0d byte reads and %0d error results.",
             delivered_seen, rdata_seen, error_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/frg_pkg.sv
hdl/frg_if.sv
hdl/frg_ram.sv
hdl/frg_alu.sv
hdl/fragment_reassembler.sv
tb/sv/reasm_checker.sv
tb/sv/testbench.sv
